// ===== rtl/core/sxm_pkg.sv =====
package sxm_pkg;

  localparam int VALUE_W        = 8;
  localparam int TARGET_W       = 8;
  localparam int MAX_VALUE_BITS = 16;
  localparam int DEF_VALUE_BITS = 8;
  localparam int HIST_W         = 11;
  localparam int TOTAL_W        = 20;
  localparam int EPOCH_BITS     = 8;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [HIST_W-1:0]     HIST_MAX  = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

  // register index, taken from paddr[2]
  localparam logic REG_TARGET = 1'b0;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [HIST_W-1:0]     count;
  } hist_word_t;

endpackage

// ===== rtl/core/sxm_in_if.sv =====
interface sxm_in_if import sxm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source(output valid, value, last, input ready);
  modport sink(input valid, value, last, output ready);
endinterface

// ===== rtl/core/sxm_out_if.sv =====
interface sxm_out_if import sxm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] match_total;
  logic               last_res;

  modport source(output valid, match_total, last_res, input ready);
  modport sink(input valid, match_total, last_res, output ready);
endinterface

// ===== rtl/core/subarray_xor_match_counter.sv =====
// Counts contiguous runs of a value stream whose XOR equals the target register.
// in_ch carries value and last; out_ch returns one transaction per input
// transaction with the running match_total and last_res (a copy of last).
// The prefix histogram sits in a RAM with two read ports and one write port;
// each transaction reads two entries, updates one and writes it back.
// Throughput: one transaction per cycle unless out_ch stalls or the RAM is clearing,
// set by the single RAM write port; a write that meets a read of the same entry in
// the same cycle is forwarded. A result passes the histogram stage, then the output register.
// The output register and the histogram stage act as a two-deep buffer:
// while the receiver stalls, one more input is accepted, then in_ch.ready drops.
// Sequences are closed by last; the histogram is cleared by bumping an epoch
// tag stored with each entry, so no sweep is needed per sequence.
// After reset, and after every 255th sequence when the epoch wraps, a clearing pass
// sweeps all 2**VALUE_BITS entries; in_ch.ready stays low meanwhile. Reset sets target
// to 0. The user must write target (APB address 0) only while idle; not enforced.
module subarray_xor_match_counter import sxm_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  sxm_in_if.sink             in_ch,
  sxm_out_if.source          out_ch
);

  localparam int AW = VALUE_BITS;

  logic [TARGET_W-1:0]   target;
  logic [AW-1:0]         prefix;
  logic                  clearing;
  logic [AW-1:0]         clr_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic                  s1_valid;
  logic                  s1_last;
  logic [AW-1:0]         s1_addr;
  logic [AW-1:0]         s1_want;
  logic                  fwd_self;
  logic                  fwd_want;
  logic [HIST_W-1:0]     fwd_count;
  logic [TOTAL_W-1:0]    total;
  logic                  out_valid;
  logic [TOTAL_W-1:0]    out_total;
  logic                  out_last;

  logic [MAX_VALUE_BITS-1:0] value_wide;
  logic [MAX_VALUE_BITS-1:0] target_wide;
  logic [AW-1:0]             p_in;
  logic [AW-1:0]             want_in;
  logic                      s1_move;
  logic                      wrap_hold;
  logic                      in_ready;
  logic                      accept;
  logic                      cfg_write;
  hist_word_t                rd_a;
  hist_word_t                rd_b;
  hist_word_t                wr_data;
  logic                      we;
  logic [AW-1:0]             wr_addr;
  logic [HIST_W-1:0]         self_cnt;
  logic [HIST_W-1:0]         want_cnt;
  logic [HIST_W-1:0]         self_inc;
  logic [TOTAL_W:0]          sum;
  logic [TOTAL_W-1:0]        sat_total;

  // APB
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TARGET);
  assign prdata    = (paddr[2] == REG_TARGET) ? PDATA_W'(target) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_write) begin
      target <= pwdata[TARGET_W-1:0];
    end
  end

  // stage 0: prefix update and RAM read
  assign value_wide  = MAX_VALUE_BITS'(in_ch.value);
  assign target_wide = MAX_VALUE_BITS'(target);
  assign p_in        = prefix ^ value_wide[AW-1:0];
  assign want_in     = p_in ^ target_wide[AW-1:0];

  assign s1_move   = s1_valid && (!out_valid || out_ch.ready);
  assign wrap_hold = s1_valid && s1_last && (epoch == EPOCH_MAX);
  assign in_ready  = !clearing && !wrap_hold && (!s1_valid || s1_move);
  assign accept    = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // stage 1: resolve counts; stale epoch reads as the reset histogram
  always_comb begin
    if (fwd_self) begin
      self_cnt = fwd_count;
    end else if (rd_a.tag == epoch) begin
      self_cnt = rd_a.count;
    end else begin
      self_cnt = (s1_addr == '0) ? HIST_W'(1) : '0;
    end
    if (fwd_want) begin
      want_cnt = fwd_count;
    end else if (rd_b.tag == epoch) begin
      want_cnt = rd_b.count;
    end else begin
      want_cnt = (s1_want == '0) ? HIST_W'(1) : '0;
    end
  end

  assign self_inc  = (self_cnt == HIST_MAX) ? self_cnt : self_cnt + HIST_W'(1);
  assign sum       = {1'b0, total} + (TOTAL_W + 1)'(want_cnt);
  assign sat_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign we      = clearing || s1_move;
  assign wr_addr = clearing ? clr_addr : s1_addr;
  always_comb begin
    if (clearing) begin
      wr_data = '{tag: '0, count: '0};
    end else begin
      wr_data = '{tag: epoch, count: self_inc};
    end
  end

  sxm_hist_ram #(.VALUE_BITS(VALUE_BITS)) u_hist (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (p_in),
    .rd_addr_b (want_in),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix    <= '0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      epoch     <= EPOCH_FIRST;
      s1_valid  <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        prefix <= in_ch.last ? '0 : p_in;
      end

      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == '1) begin
          clearing <= 1'b0;
          epoch    <= EPOCH_FIRST;
        end
      end else if (s1_move && s1_last) begin
        if (epoch == EPOCH_MAX) begin
          clearing <= 1'b1;
          clr_addr <= '0;
        end else begin
          epoch <= epoch + EPOCH_BITS'(1);
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        total     <= s1_last ? '0 : sat_total;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last   <= in_ch.last;
      s1_addr   <= p_in;
      s1_want   <= want_in;
      // write-back landing in the read cycle of this transaction
      fwd_self  <= s1_move && !s1_last && (s1_addr == p_in);
      fwd_want  <= s1_move && !s1_last && (s1_addr == want_in);
      fwd_count <= self_inc;
    end
    if (s1_move) begin
      out_total <= sat_total;
      out_last  <= s1_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.match_total = out_total;
  assign out_ch.last_res    = out_last;

endmodule

// ===== rtl/core/sxm_hist_ram.sv =====
module sxm_hist_ram import sxm_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [VALUE_BITS-1:0] rd_addr_a,
  input  logic [VALUE_BITS-1:0] rd_addr_b,
  output hist_word_t            rd_data_a,
  output hist_word_t            rd_data_b,
  input  logic                  we,
  input  logic [VALUE_BITS-1:0] wr_addr,
  input  hist_word_t            wr_data
);

  localparam int DEPTH = 1 << VALUE_BITS;

  hist_word_t mem [DEPTH];

  // read returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== tb/sv/sxm_match_checker.sv =====
module sxm_match_checker import sxm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  sxm_in_if                  in_mon,
  sxm_out_if                 out_mon,
  output int                 mismatches,
  output int                 outstanding,
  output int                 compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS = 1 << DEF_VALUE_BITS;

  typedef struct packed {
    logic [TOTAL_W-1:0] match_total;
    logic               last_res;
  } match_result_t;

  logic [TARGET_W-1:0] target_reg;
  logic [VALUE_W-1:0]  run_xor;
  logic [HIST_W-1:0]   xor_seen [BINS];
  logic [TOTAL_W-1:0]  run_total;
  match_result_t       expected_totals [$];
  match_result_t       want;
  int                  err_n = 0;
  int                  cmp_n = 0;

  function automatic void restart_sequence();
    run_xor = '0;
    foreach (xor_seen[i]) xor_seen[i] = '0;
    xor_seen[0] = HIST_W'(1);
    run_total = '0;
  endfunction

  function automatic match_result_t count_matches(input logic [VALUE_W-1:0] v,
                                                  input logic l);
    logic [TOTAL_W:0] sum;
    match_result_t    r;
    run_xor = run_xor ^ v;
    sum = {1'b0, run_total} + (TOTAL_W+1)'(xor_seen[run_xor ^ target_reg]);
    run_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    if (xor_seen[run_xor] != HIST_MAX) begin
      xor_seen[run_xor] = xor_seen[run_xor] + HIST_W'(1);
    end
    r.match_total = run_total;
    r.last_res    = l;
    if (l) begin
      restart_sequence();
    end
    return r;
  endfunction

  function automatic void flag(input string what);
    err_n++;
    if (err_n <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      target_reg = '0;
      restart_sequence();
      expected_totals.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_TARGET) begin
        if (pwrite) begin
          target_reg = pwdata[TARGET_W-1:0];
        end else if (prdata[TARGET_W-1:0] !== target_reg) begin
          flag($sformatf("target read: expected %0h, got %0h",
                         target_reg, prdata[TARGET_W-1:0]));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_totals.push_back(count_matches(in_mon.value, in_mon.last));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_totals.size() == 0) begin
          flag($sformatf("unexpected result: total %0d last %0b",
                         out_mon.match_total, out_mon.last_res));
        end else begin
          want = expected_totals.pop_front();
          cmp_n++;
          if (out_mon.match_total !== want.match_total ||
              out_mon.last_res !== want.last_res) begin
            flag($sformatf("result %0d: expected total %0d last %0b, got total %0d last %0b",
                           cmp_n, want.match_total, want.last_res,
                           out_mon.match_total, out_mon.last_res));
          end
        end
      end
    end
    mismatches  <= err_n;
    outstanding <= expected_totals.size();
    compared    <= cmp_n;
  end

endmodule

// ===== tb/sv/tb_subarray_xor_match_counter.sv =====
module tb_subarray_xor_match_counter import sxm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int ZERO_RUN      = 32;
  localparam int RANDOM_ITEMS  = 600;
  localparam int MIN_SEQUENCES = 262;
  localparam int PHASE_ITEMS   = 60;

  typedef enum int {MIX_SPREAD, MIX_ALPHABET, MIX_NARROW} value_mix_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sxm_in_if  in_ch ();
  sxm_out_if out_ch ();

  int mismatches;
  int outstanding;
  int compared;
  int cycle_n   = 0;
  int sent_n    = 0;
  int seq_n     = 0;
  int setting_n = 0;
  bit calm       = 1'b0;
  bit drain_next = 1'b0;

  subarray_xor_match_counter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  sxm_match_checker chk (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_n);
      $display("subarray_xor_match_counter regression: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    if (calm || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(1, 14);
  endfunction

  // result side: random stalls per transaction
  initial begin
    int unsigned gap;
    gap = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      gap = draw_wait();
    end
  end

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
    int unsigned gap;
    bit          hold;
    gap  = draw_wait();
    hold = drain_next || (!calm && $urandom_range(0, 49) == 0);
    drain_next = 1'b0;
    if (hold || gap != 0) begin
      in_ch.valid <= 1'b0;
    end
    if (hold) begin
      do @(posedge clk); while (outstanding != 0);
    end
    repeat (gap) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
    sent_n++;
    if (l) begin
      seq_n++;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || !in_ch.ready);
  endtask

  task automatic reg_access(input logic wr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_TARGET, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_target(input logic [PDATA_W-1:0] data);
    settle();
    reg_access(1'b1, data);
    reg_access(1'b0, '0);
    setting_n++;
  endtask

  initial begin
    int                  phase;
    int                  phase_start;
    int                  rand_n;
    int                  len;
    int unsigned         kind;
    value_mix_t          mix;
    logic [TARGET_W-1:0] tgt;
    logic [VALUE_W-1:0]  a;
    logic [VALUE_W-1:0]  v;

    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset value of target, then short sequences at target 0
    settle();
    reg_access(1'b0, '0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);

    // upper write bits must be ignored
    set_target(32'hA5A5_A5FF);
    drain_next = 1'b1;
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b1);

    set_target(32'h0000_005A);
    send_item(8'h5A, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h5A, 1'b1);

    // all-zero run back to back: one entry keeps hitting its own forwarded count
    set_target(32'h0000_0000);
    calm = 1'b1;
    for (int i = 0; i < ZERO_RUN; i++) begin
      send_item(8'h00, i == ZERO_RUN - 1);
    end
    calm = 1'b0;
    send_item(8'h3C, 1'b1);

    phase  = 0;
    rand_n = 0;
    while (rand_n < RANDOM_ITEMS || seq_n < MIN_SEQUENCES) begin
      case (phase % 4)
        0:       tgt = 8'h00;
        1:       tgt = 8'hFF;
        default: tgt = TARGET_W'($urandom());
      endcase
      set_target({(PDATA_W-TARGET_W)'($urandom()), tgt});
      calm = (phase % 5 == 3);
      phase_start = rand_n;
      while (rand_n - phase_start < PHASE_ITEMS) begin
        kind = $urandom_range(0, 19);
        if (kind < 17) begin
          len = int'($urandom_range(1, 2));
        end else if (kind < 19) begin
          len = int'($urandom_range(3, 10));
        end else begin
          len = int'($urandom_range(11, 24));
        end
        mix = value_mix_t'($urandom_range(0, 2));
        a   = VALUE_W'($urandom());
        for (int i = 0; i < len; i++) begin
          case (mix)
            MIX_SPREAD: v = VALUE_W'($urandom());
            MIX_ALPHABET: begin
              case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = tgt;
                2:       v = a;
                default: v = a ^ tgt;
              endcase
            end
            default: v = VALUE_W'($urandom_range(0, 3));
          endcase
          send_item(v, i == len - 1);
        end
        rand_n += len;
      end
      phase++;
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    $display("run covered %0d input transactions in %0d sequences under %0d target settings",
             sent_n, seq_n, setting_n);
    $display("%0d results checked, including a %0d-item all-zero sequence",
             compared, ZERO_RUN);
    if (mismatches == 0) begin
      $display("subarray_xor_match_counter regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("subarray_xor_match_counter regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sxm_pkg.sv
rtl/core/sxm_in_if.sv
rtl/core/sxm_out_if.sv
rtl/core/sxm_hist_ram.sv
rtl/core/subarray_xor_match_counter.sv
tb/sv/sxm_match_checker.sv
tb/sv/tb_subarray_xor_match_counter.sv
